// ===== sv/sliding_window_median_macros.svh =====
// Assertion macros for the sliding-window median filter.
// Used by the top level; needs no other file.
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on rising clock, ignored while reset is asserted.
`define SWM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked on rising clock, during reset as well.
`define SWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWM_ASSERT(lbl, clk, rstn, prop, msg)
`define SWM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/swm_pkg.sv =====
// Shared types and constants of the sliding-window median filter.
// No dependencies.
`default_nettype none

package swm_pkg;

  // Width and reset value of the window size register.
  localparam int unsigned CFG_BITS  = 7;
  localparam int unsigned CFG_RESET = 3;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic full;      // window full: the oldest sample leaves this transfer
    logic rm_le;     // the leaving sample is <= the new sample
  } swm_ctrl_t;

  // Flags handed from a cell to its right neighbor.
  typedef struct packed {
    logic rm_seen;   // leaving sample sits at this cell or to its left
    logic ins_le;    // insert position is at or left of this cell
  } swm_link_t;

endpackage

`default_nettype wire

// ===== sv/swm_in_if.sv =====
// Sample input channel of the median filter.
// Depends on nothing.
`default_nettype none

interface swm_in_if #(
  parameter int unsigned SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

`default_nettype wire

// ===== sv/swm_out_if.sv =====
// Median output channel of the median filter.
// Depends on nothing.
`default_nettype none

interface swm_out_if #(
  parameter int unsigned SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

// ===== sv/swm_cfg_if.sv =====
// Window size write channel of the median filter.
// Depends on swm_pkg.
`default_nettype none

interface swm_cfg_if;
  import swm_pkg::*;

  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

`default_nettype wire

// ===== sv/swm_cell.sv =====
// One cell of the sorted window chain: a sample value and its age.
// Depends on swm_pkg.
`default_nettype none

module swm_cell #(
  parameter int unsigned SAMPLE_BITS = 32,
  parameter int unsigned AGE_BITS    = 6
) (
  input  wire                             clk_i,
  input  wire                             upd_i,
  input  wire swm_pkg::swm_ctrl_t         ctrl_i,
  input  wire signed [SAMPLE_BITS-1:0]    key_i,
  input  wire        [AGE_BITS-1:0]       age_last_i,
  input  wire                             valid_i,
  input  wire signed [SAMPLE_BITS-1:0]    left_val_i,
  input  wire        [AGE_BITS-1:0]       left_age_i,
  input  wire swm_pkg::swm_link_t         left_link_i,
  input  wire signed [SAMPLE_BITS-1:0]    right_val_i,
  input  wire        [AGE_BITS-1:0]       right_age_i,
  input  wire                             right_le_i,
  output logic signed [SAMPLE_BITS-1:0]   val_o,
  output logic        [AGE_BITS-1:0]      age_o,
  output logic                            le_o,
  output logic                            rm_o,
  output logic                            rm_le_o,
  output swm_pkg::swm_link_t              link_o
);
  import swm_pkg::*;

  logic signed [SAMPLE_BITS-1:0] val_q, val_d;
  logic        [AGE_BITS-1:0]    age_q, age_d;

  always_comb begin
    le_o           = valid_i && (val_q <= key_i);
    rm_o           = ctrl_i.full && valid_i && (age_q == age_last_i);
    rm_le_o        = rm_o && le_o;
    link_o.rm_seen = left_link_i.rm_seen | rm_o;
    // insert slot at or left of here; one slot less if the leaver was <= key
    link_o.ins_le  = ctrl_i.rm_le ? !right_le_i : !le_o;
  end

  // New content: compacted neighbor left of the insert slot, the key at it,
  // shifted neighbor right of it.
  always_comb begin
    if (!link_o.ins_le) begin
      if (link_o.rm_seen) begin
        val_d = right_val_i;
        age_d = right_age_i + AGE_BITS'(1);
      end else begin
        val_d = val_q;
        age_d = age_q + AGE_BITS'(1);
      end
    end else if (!left_link_i.ins_le) begin
      val_d = key_i;
      age_d = '0;
    end else if (left_link_i.rm_seen) begin
      val_d = val_q;
      age_d = age_q + AGE_BITS'(1);
    end else begin
      val_d = left_val_i;
      age_d = left_age_i + AGE_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o = val_q;
  assign age_o = age_q;

endmodule

`default_nettype wire

// ===== sv/sliding_window_median.sv =====
// Top level of the sliding-window median filter: cell chain, fill control,
// output stage. Depends on swm_pkg, the channel interfaces, swm_cell and the
// assertion macro header.
//
//  channel   | dir | payload                   | transfer when
//  ----------+-----+---------------------------+----------------------------
//  in_i      | in  | sample, restart           | in_i.valid && in_i.ready
//  out_o     | out | median                    | out_o.valid && out_o.ready
//  cfg_i     | in  | window_size               | cfg_i.valid && cfg_i.ready
//
// One sample per clock while in_i is ready: each transfer updates the whole
// sorted chain at once (remove oldest, insert new, neighbors shift by one).
// A median reaches out_o after its sample's transfer by way of the chain
// update and then the median select register. in_i stalls only while a
// median waits for the select stage and out_o is held. Reset empties the
// window and sets the window size to three; a window size write empties the
// window too. Cell contents need no reset.
`default_nettype none

`include "sliding_window_median_macros.svh"

module sliding_window_median #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  wire     clk_i,
  input  wire     rst_ni,
  swm_in_if.sink  in_i,
  swm_out_if.source out_o,
  swm_cfg_if.sink cfg_i
);
  import swm_pkg::*;

  localparam int unsigned AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned KW      = $clog2(MAX_WINDOW + 1);
  localparam int unsigned K_RESET = (CFG_RESET > MAX_WINDOW) ? MAX_WINDOW : CFG_RESET;

  // Window size, already clamped to 1..MAX_WINDOW, and the median slot.
  logic [KW-1:0] k_q, k_d;
  logic [AW-1:0] mid_q, mid_d;
  logic [KW-1:0] fill_q, fill_d;
  logic          pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] median_q, median_d;

  logic          in_fire, cfg_fire, out_free;
  logic [KW-1:0] fill_eff, fill_next;
  logic          full, emit;
  swm_ctrl_t     ctrl;
  logic [AW-1:0] age_last;

  // Chain wiring.
  logic signed [SAMPLE_BITS-1:0] cell_val   [MAX_WINDOW];
  logic        [AW-1:0]          cell_age   [MAX_WINDOW];
  swm_link_t                     cell_link  [MAX_WINDOW];
  logic        [MAX_WINDOW-1:0]  cell_le, cell_rm, cell_rm_le, cell_valid;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  assign out_free    = !out_valid_q || out_o.ready;
  // Chain may change only once the pending median has been picked up.
  assign in_i.ready  = !pend_q || out_free;
  assign in_fire     = in_i.valid && in_i.ready;

  // Restart drops the window before this sample goes in.
  assign fill_eff  = in_i.restart ? '0 : fill_q;
  assign full      = (fill_eff == k_q);
  assign fill_next = full ? k_q : fill_eff + KW'(1);
  assign emit      = (fill_next == k_q);
  assign age_last  = AW'(k_q - KW'(1));

  assign ctrl.full  = full;
  assign ctrl.rm_le = |cell_rm_le;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] lval, rval;
    logic        [AW-1:0]          lage, rage;
    swm_link_t                     llink;
    logic                          rle;

    assign cell_valid[i] = (KW'(i) < fill_eff);

    if (i == 0) begin : g_first
      assign lval  = '0;
      assign lage  = '0;
      assign llink = '0;
    end else begin : g_mid
      assign lval  = cell_val[i-1];
      assign lage  = cell_age[i-1];
      assign llink = cell_link[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign rval = '0;
      assign rage = '0;
      assign rle  = 1'b0;
    end else begin : g_inner
      assign rval = cell_val[i+1];
      assign rage = cell_age[i+1];
      assign rle  = cell_le[i+1];
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_BITS    (AW)
    ) u_cell (
      .clk_i       (clk_i),
      .upd_i       (in_fire),
      .ctrl_i      (ctrl),
      .key_i       (in_i.sample),
      .age_last_i  (age_last),
      .valid_i     (cell_valid[i]),
      .left_val_i  (lval),
      .left_age_i  (lage),
      .left_link_i (llink),
      .right_val_i (rval),
      .right_age_i (rage),
      .right_le_i  (rle),
      .val_o       (cell_val[i]),
      .age_o       (cell_age[i]),
      .le_o        (cell_le[i]),
      .rm_o        (cell_rm[i]),
      .rm_le_o     (cell_rm_le[i]),
      .link_o      (cell_link[i])
    );
  end

  // Window size write: clamp once here so the chain never sees zero or
  // an oversize window.
  always_comb begin
    k_d   = k_q;
    mid_d = mid_q;
    if (cfg_fire) begin
      if (cfg_i.window_size == '0) begin
        k_d = KW'(1);
      end else if (32'(cfg_i.window_size) > 32'(MAX_WINDOW)) begin
        k_d = KW'(MAX_WINDOW);
      end else begin
        k_d = KW'(cfg_i.window_size);
      end
      mid_d = AW'((k_d - KW'(1)) >> 1);
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (cfg_fire) begin
      fill_d = '0;
    end else if (in_fire) begin
      fill_d = fill_next;
    end
  end

  // pend: chain holds a fresh median not yet moved to the output register.
  always_comb begin
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    median_d    = median_q;
    if (out_free) begin
      out_valid_d = pend_q;
      median_d    = cell_val[mid_q];
      pend_d      = 1'b0;
    end
    if (in_fire) begin
      pend_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= KW'(K_RESET);
      mid_q       <= AW'((K_RESET - 1) / 2);
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      mid_q       <= mid_d;
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    median_q <= median_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.median = median_q;

  // Fill count never runs past the window.
  `SWM_ASSERT(a_fill_in_range, clk_i, rst_ni, fill_q <= k_q, "fill count above window size")
  // A full window loses exactly one cell per sample.
  `SWM_ASSERT(a_one_leaver, clk_i, rst_ni, (in_fire && full) |-> $onehot(cell_rm), "not exactly one cell removed")
  // No removal while the window is still filling.
  `SWM_ASSERT(a_no_early_rm, clk_i, rst_ni, !full |-> (cell_rm == '0), "cell removed before window full")
  // A sample after which the window is full leaves a pending median.
  `SWM_ASSERT(a_emit_pend, clk_i, rst_ni, (in_fire && emit) |=> pend_q, "median lost after full window")

endmodule

`default_nettype wire

// ===== tb/swm_median_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the sliding-window median filter: follows window size writes
// and sample transfers, predicts every median and checks the output channel.
// Depends on swm_pkg.
module swm_median_checker #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_i,
  input  logic                          in_restart_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] out_median_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [swm_pkg::CFG_BITS-1:0]  cfg_window_size_i,
  output int unsigned                   fail_cnt_o,
  output int unsigned                   owed_cnt_o,
  output int unsigned                   checked_cnt_o
);
  import swm_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  sample_t     arrival_ring [MAX_WINDOW];  // window in arrival order
  sample_t     sorted_vals  [MAX_WINDOW];  // same values, ascending
  int unsigned ring_oldest;
  int unsigned fill;
  int unsigned win_reg;
  sample_t     median_due [$];
  sample_t     want;

  task automatic sorted_add(input sample_t v);
    int unsigned i;
    i = fill;
    while (i > 0 && sorted_vals[i-1] > v) begin
      sorted_vals[i] = sorted_vals[i-1];
      i--;
    end
    sorted_vals[i] = v;
    fill++;
  endtask

  task automatic window_step(input sample_t s, input logic restart);
    int unsigned k;
    int unsigned slot;
    int unsigned i;
    // size 0 acts as 1, sizes past the store saturate
    k = (win_reg == 0) ? 1 : ((win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg);
    if (restart) begin
      fill        = 0;
      ring_oldest = 0;
    end
    if (fill < k) begin
      arrival_ring[fill] = s;
      sorted_add(s);
      ring_oldest = 0;
    end else begin
      slot = (ring_oldest >= k) ? 0 : ring_oldest;
      // drop one copy of the leaving value, duplicates stay
      i = 0;
      while (i < fill && sorted_vals[i] != arrival_ring[slot]) i++;
      if (i < fill) begin
        while (i + 1 < fill) begin
          sorted_vals[i] = sorted_vals[i+1];
          i++;
        end
        fill--;
      end
      sorted_add(s);
      arrival_ring[slot] = s;
      ring_oldest = (slot + 1 >= k) ? 0 : slot + 1;
    end
    if (fill >= k) median_due.push_back(sorted_vals[(k-1)/2]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_reg       = CFG_RESET;
      fill          = 0;
      ring_oldest   = 0;
      median_due.delete();
      fail_cnt_o    = 0;
      owed_cnt_o    = 0;
      checked_cnt_o = 0;
    end else begin
      // output first: a median never belongs to a sample of the same edge
      if (out_valid_i && out_ready_i) begin
        if (median_due.size() == 0) begin
          $display("%0t: median %0d arrived with none expected", $time, out_median_i);
          fail_cnt_o++;
        end else begin
          want = median_due.pop_front();
          checked_cnt_o++;
          if (out_median_i !== want) begin
            $display("%0t: median mismatch: expected %0d, actual %0d",
                     $time, want, out_median_i);
            fail_cnt_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        win_reg     = cfg_window_size_i;
        fill        = 0;
        ring_oldest = 0;
      end
      if (in_valid_i && in_ready_i) window_step(in_sample_i, in_restart_i);
      owed_cnt_o = median_due.size();
    end
  end

endmodule

// ===== tb/tb_sliding_window_median.sv =====
`timescale 1ns / 100ps
// Top of the median filter testbench: clock, reset, sample and window size
// stimulus, receiver back-pressure and verdict. Depends on swm_pkg, the three
// channel interfaces, sliding_window_median and swm_median_checker.
module tb_sliding_window_median;
  import swm_pkg::*;

  localparam int unsigned MAX_WINDOW  = 64;
  localparam int unsigned SAMPLE_BITS = 32;
  // Cycles without any transfer before the run is called hung. The worst
  // correct gap is a long run of sender idles or receiver stalls at 74 %.
  localparam int unsigned HANG_LIMIT  = 2000;
  // A sample that makes no median can still sit in the chain update or the
  // select stage when the last median is out; SETTLE covers it with margin.
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned END_TAIL    = 8;

  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  typedef enum int unsigned {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  int unsigned send_idle_pct;   // chance per cycle that the sender holds off
  int unsigned recv_stall_pct;  // chance per cycle that out ready is low
  int unsigned sent_cnt;
  int unsigned restart_cnt;
  int unsigned cfg_cnt;
  int unsigned hang_cnt;

  int unsigned fail_cnt;
  int unsigned owed_cnt;
  int unsigned checked_cnt;

  always #5 clk = ~clk;

  swm_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  swm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();
  swm_cfg_if                              cfg_ch ();

  sliding_window_median #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  swm_median_checker #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_ch.valid),
    .in_ready_i       (in_ch.ready),
    .in_sample_i      (in_ch.sample),
    .in_restart_i     (in_ch.restart),
    .out_valid_i      (out_ch.valid),
    .out_ready_i      (out_ch.ready),
    .out_median_i     (out_ch.median),
    .cfg_valid_i      (cfg_ch.valid),
    .cfg_ready_i      (cfg_ch.ready),
    .cfg_window_size_i(cfg_ch.window_size),
    .fail_cnt_o       (fail_cnt),
    .owed_cnt_o       (owed_cnt),
    .checked_cnt_o    (checked_cnt)
  );

  // Receiver back-pressure, redrawn at every falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Hang watchdog: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        hang_cnt <= 0;
      end else if (hang_cnt + 1 >= HANG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
        $display("tb_sliding_window_median NOT OK");
        $finish;
      end else begin
        hang_cnt <= hang_cnt + 1;
      end
    end
  end

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 74; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 74; end
      default:   begin send_idle_pct = 8;  recv_stall_pct = 8;  end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  // valid gets exactly one assignment per falling edge, so back-to-back
  // samples keep it high without a glitch.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic restart);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= s;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent_cnt++;
    if (restart) restart_cnt++;
  endtask

  // Drop valid, wait until every owed median is out, then idle some more.
  task automatic hold_until_drained(input int unsigned tail);
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (owed_cnt != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  // Window size writes happen only with the filter idle; each one also
  // empties the window.
  task automatic write_window(input logic [CFG_BITS-1:0] size);
    hold_until_drained(SETTLE);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.window_size <= size;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cfg_cnt++;
  endtask

  // One random phase. Samples mix extremes, a narrow pool around zero for
  // plenty of equal values, and full-range noise. Restarts are rare so that
  // long windows still fill and produce medians.
  task automatic run_phase(input logic [CFG_BITS-1:0] size, input int unsigned n,
                           input idle_mode_e mode, input int unsigned restart_pct,
                           input bit pause_mid);
    int unsigned roll;
    logic signed [SAMPLE_BITS-1:0] s;
    write_window(size);
    set_idle(mode);
    for (int unsigned i = 0; i < n; i++) begin
      // sender stops once mid-phase until the pipeline is empty
      if (pause_mid && i == n / 2) hold_until_drained(0);
      roll = $urandom_range(0, 7);
      case (roll)
        0: begin
          case ($urandom_range(0, 3))
            0:       s = S_MIN;
            1:       s = S_MAX;
            2:       s = '0;
            default: s = '1;
          endcase
        end
        1, 2, 3: s = $signed($urandom_range(0, 8)) - 4;
        default: s = $urandom;
      endcase
      send_sample(s, $urandom_range(0, 99) < restart_pct);
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.sample       = '0;
    in_ch.restart      = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.window_size = '0;
    out_ch.ready       = 1'b1;
    hang_cnt           = 0;
    sent_cnt           = 0;
    restart_cnt        = 0;
    cfg_cnt            = 0;
    set_idle(IDLE_NONE);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: reset window of three, extremes and sign boundary.
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample('0, 1'b0);        // first median: 0
    send_sample('1, 1'b0);
    send_sample(1, 1'b0);
    // equal values enter and leave one copy at a time
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(-7, 1'b0);
    // restart mid-stream, then two restarts in a row
    send_sample(9, 1'b1);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(3, 1'b1);
    send_sample(4, 1'b1);
    send_sample(2, 1'b0);

    // window of one passes samples through, restart or not
    write_window(1);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
    send_sample('1, 1'b0);
    send_sample('0, 1'b0);

    // size zero behaves as one
    write_window(0);
    send_sample(42, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b1);

    // even window: lower of the two middle values
    write_window(2);
    send_sample(10, 1'b0);
    send_sample(-10, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);

    // Random phases; 127 checks saturation to the largest window.
    run_phase(5,   60, IDLE_NONE, 8,  1'b0);
    run_phase(64,  90, IDLE_SEND, 1,  1'b0);
    run_phase(127, 75, IDLE_RECV, 0,  1'b0);
    run_phase(4,   50, IDLE_BOTH, 10, 1'b1);
    run_phase(CFG_BITS'($urandom_range(1, 16)), 60, IDLE_SEND, 6, 1'b0);
    run_phase(8,   60, IDLE_RECV, 5,  1'b1);
    run_phase(3,   55, IDLE_BOTH, 8,  1'b0);

    hold_until_drained(END_TAIL);

    $display("Covered %0d samples (%0d restarts) over %0d window size writes, sizes 0..127;",
             sent_cnt, restart_cnt, cfg_cnt);
    $display("%0d medians checked, %0d failures, %0d medians still owed.",
             checked_cnt, fail_cnt, owed_cnt);
    if (fail_cnt == 0 && owed_cnt == 0) begin
      $display("tb_sliding_window_median OK");
    end else begin
      $display("tb_sliding_window_median NOT OK");
    end
    $finish;
  end

endmodule
